FILE: rtl/pnf_pkg.sv
package pnf_pkg;

   typedef struct packed {
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] noise_value;
      logic               saturated_flag;
   } rsp_type;

   localparam logic [1:0] CSR_SEED   = 2'd0;
   localparam logic [1:0] CSR_MODE   = 2'd1;
   localparam logic [1:0] CSR_OCTAVE = 2'd2;

   localparam logic [1:0] MODE_PLAIN  = 2'd0;
   localparam logic [1:0] MODE_FRACT  = 2'd1;
   localparam logic [1:0] MODE_TURB   = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // gradient row table, components in {-1,0,1}
   function automatic logic [5:0] grad_row(input logic [3:0] r);
      logic [5:0] g;
      begin
         case (r)
            4'd0:    g = {2'sd1, 2'sd1, 2'sd0};
            4'd1:    g = {-2'sd1, 2'sd1, 2'sd0};
            4'd2:    g = {2'sd1, -2'sd1, 2'sd0};
            4'd3:    g = {-2'sd1, -2'sd1, 2'sd0};
            4'd4:    g = {2'sd1, 2'sd0, 2'sd1};
            4'd5:    g = {-2'sd1, 2'sd0, 2'sd1};
            4'd6:    g = {2'sd1, 2'sd0, -2'sd1};
            4'd7:    g = {-2'sd1, 2'sd0, -2'sd1};
            4'd8:    g = {2'sd0, 2'sd1, 2'sd1};
            4'd9:    g = {2'sd0, -2'sd1, 2'sd1};
            4'd10:   g = {2'sd0, 2'sd1, -2'sd1};
            4'd11:   g = {2'sd0, -2'sd1, -2'sd1};
            4'd12:   g = {2'sd1, 2'sd1, 2'sd0};
            4'd13:   g = {-2'sd1, 2'sd1, 2'sd0};
            4'd14:   g = {2'sd0, -2'sd1, 2'sd1};
            default: g = {2'sd0, -2'sd1, -2'sd1};
         endcase
         return g;
      end
   endfunction

   // signed add of one offset chosen by a gradient component
   function automatic logic signed [19:0] gterm(input logic [1:0] g,
                                                input logic signed [17:0] d);
      begin
         case (g)
            2'b01:   return 20'(d);
            2'b11:   return -20'(d);
            default: return 20'sd0;
         endcase
      end
   endfunction

endpackage

FILE: rtl/pnf_sample.sv
// One Perlin sample per cycle at a given scale exponent, fully pipelined.
// Stage 1: scale and split. Stage 2: hash products. Stage 3: hash finish and
// fade inner. Stages 4-6: fade products. Stage 7: corners. Stages 8-10: blends.
module pnf_sample #(
   parameter int SCW = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  pnf_pkg::req_type      in_point,
   input  logic [SCW-1:0]        in_scale,
   input  logic [31:0]           seed,
   input  logic [7:0]            in_tag,
   output logic                  out_valid,
   output logic signed [19:0]    out_sample,
   output logic [SCW-1:0]        out_scale,
   output logic [7:0]            out_tag
);
   localparam int DEPTH = 10;

   logic [DEPTH-1:0]     vld_ff;
   logic [SCW-1:0]       scl_ff [DEPTH];
   logic [7:0]           tag_ff [DEPTH];

   // stage 1: lattice coords and fractions
   logic [31:0] l1_ff [3];
   logic [15:0] f1_ff [3];
   // stage 2: partial hash sum
   logic [31:0] h2_ff [8];
   logic [15:0] f2_ff [3];
   // stage 3: rows and fade inner
   logic [3:0]  r3_ff [8];
   logic [15:0] f3_ff [3];
   logic [35:0] v3_ff [3];
   // stages 4..6: fade chain
   logic [35:0] v4_ff [3];
   logic [35:0] v5_ff [3];
   logic [16:0] s6_ff [3];
   logic [3:0]  r4_ff [8];
   logic [3:0]  r5_ff [8];
   logic [3:0]  r6_ff [8];
   logic [15:0] f4_ff [3];
   logic [15:0] f5_ff [3];
   logic [15:0] f6_ff [3];
   // stage 7: corners
   logic signed [19:0] c7_ff [8];
   logic [16:0]        s7_ff [3];
   // stage 8..10: blends
   logic signed [19:0] b8_ff [4];
   logic [16:0]        s8_ff [2];
   logic signed [19:0] b9_ff [2];
   logic [16:0]        s9_ff;
   logic signed [19:0] b10_ff;

   // advance control
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DEPTH-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      scl_ff[0] <= in_scale;
      tag_ff[0] <= in_tag;
      for (int k = 1; k < DEPTH; k++) begin
         scl_ff[k] <= scl_ff[k-1];
         tag_ff[k] <= tag_ff[k-1];
      end
   end

   // stage 1: shift by scale, lattice is bit 16 and up, fraction is low 16
   logic [31:0] crd [3];
   always_comb begin
      crd[0] = in_point.coord_x;
      crd[1] = in_point.coord_y;
      crd[2] = in_point.coord_z;
   end
   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         logic [47:0] v;
         v = {{16{crd[a][31]}}, crd[a]} << in_scale;
         l1_ff[a] <= v[47:16];
         f1_ff[a] <= v[15:0];
      end
   end

   // stage 2: per-corner hash sum of seeded coords
   always_ff @(posedge clock) begin
      for (int c = 0; c < 8; c++) begin
         logic [31:0] ax, by, cz;
         ax = l1_ff[0] + 32'(c & 1) + seed;
         by = l1_ff[1] + 32'((c >> 1) & 1) + seed;
         cz = l1_ff[2] + 32'((c >> 2) & 1) + seed;
         h2_ff[c] <= ax * 32'd71 + by * 32'd17 + cz * 32'd53;
      end
      f2_ff <= f1_ff;
   end

   // stage 3: finish hash; fade inner in Q4.32 (36 bits)
   always_ff @(posedge clock) begin
      for (int c = 0; c < 8; c++) begin
         logic [31:0] sh;
         sh = 32'($signed(h2_ff[c]) >>> 17);
         r3_ff[c] <= 4'(sh ^ h2_ff[c]);
      end
      for (int a = 0; a < 3; a++) begin
         v3_ff[a] <= 36'd42949672960 - 36'(36'd983040 * f2_ff[a])
                     + 36'(36'd6 * f2_ff[a] * f2_ff[a]);
      end
      f3_ff <= f2_ff;
   end

   // stages 4..6: three multiply-by-t with truncating shift
   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         logic [51:0] p4, p5, p6;
         p4 = 52'(v3_ff[a]) * 52'(f3_ff[a]);
         v4_ff[a] <= p4[51:16];
         p5 = 52'(v4_ff[a]) * 52'(f4_ff[a]);
         v5_ff[a] <= p5[51:16];
         p6 = 52'(v5_ff[a]) * 52'(f5_ff[a]);
         s6_ff[a] <= p6[48:32];
      end
      f4_ff <= f3_ff;
      f5_ff <= f4_ff;
      f6_ff <= f5_ff;
      r4_ff <= r3_ff;
      r5_ff <= r4_ff;
      r6_ff <= r5_ff;
   end

   // stage 7: corner dot products
   always_ff @(posedge clock) begin
      for (int c = 0; c < 8; c++) begin
         logic [5:0] g;
         logic signed [17:0] dx, dy, dz;
         g  = pnf_pkg::grad_row(r6_ff[c]);
         dx = ((c & 1) != 0) ? $signed({2'b0, f6_ff[0]}) - 18'sd65536
                             : $signed({2'b0, f6_ff[0]});
         dy = ((c & 2) != 0) ? $signed({2'b0, f6_ff[1]}) - 18'sd65536
                             : $signed({2'b0, f6_ff[1]});
         dz = ((c & 4) != 0) ? $signed({2'b0, f6_ff[2]}) - 18'sd65536
                             : $signed({2'b0, f6_ff[2]});
         c7_ff[c] <= pnf_pkg::gterm(g[5:4], dx) + pnf_pkg::gterm(g[3:2], dy)
                     + pnf_pkg::gterm(g[1:0], dz);
      end
      s7_ff <= s6_ff;
   end

   function automatic logic signed [19:0] lerp(input logic [16:0] s,
                                               input logic signed [19:0] a,
                                               input logic signed [19:0] b);
      logic signed [21:0] d;
      logic signed [39:0] p;
      begin
         d = 22'(b) - 22'(a);
         p = 40'($signed({1'b0, s})) * 40'(d);
         return a + 20'(p >>> 16);
      end
   endfunction

   // stages 8..10: x, y, z blends
   always_ff @(posedge clock) begin
      for (int j = 0; j < 4; j++) begin
         b8_ff[j] <= lerp(s7_ff[0], c7_ff[2*j], c7_ff[2*j+1]);
      end
      s8_ff[0] <= s7_ff[1];
      s8_ff[1] <= s7_ff[2];
      b9_ff[0] <= lerp(s8_ff[0], b8_ff[0], b8_ff[1]);
      b9_ff[1] <= lerp(s8_ff[0], b8_ff[2], b8_ff[3]);
      s9_ff    <= s8_ff[1];
      b10_ff   <= lerp(s9_ff, b9_ff[0], b9_ff[1]);
   end

   assign out_valid  = vld_ff[DEPTH-1];
   assign out_sample = b10_ff;
   assign out_scale  = scl_ff[DEPTH-1];
   assign out_tag    = tag_ff[DEPTH-1];
endmodule

FILE: rtl/perlin_noise_3d_fractal.sv
// Channel   | Ports                         | Beat
// request   | start, busy, req_point        | start & !busy
// response  | rsp_valid, rsp_result         | rsp_valid, one cycle
// config    | csr_we, csr_index, csr_wdata  | csr_we
// A point takes octave_count+1 passes (1 in plain or unused mode) through the
// shared sample pipeline; one pass enters per cycle, and a new point is taken
// once the last pass of the previous point has entered. Octave passes arrive
// back to back and are summed in one accumulator.
// Synchronous reset clears control. The receiver cannot stall; results
// leave in entry order.
module perlin_noise_3d_fractal #(
   parameter int MAX_OCTAVE = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  pnf_pkg::req_type    req_point,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   output logic                rsp_valid,
   output pnf_pkg::rsp_type    rsp_result
);
   localparam int SCW = (MAX_OCTAVE < 1) ? 1 : $clog2(MAX_OCTAVE + 1);

   logic [31:0]    seed_ff;
   logic [1:0]     mode_ff;
   logic [2:0]     oct_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'd55;
         mode_ff <= pnf_pkg::MODE_PLAIN;
         oct_ff  <= 3'd0;
      end else if (csr_we) begin
         case (csr_index)
            pnf_pkg::CSR_SEED:   seed_ff <= csr_wdata;
            pnf_pkg::CSR_MODE:   mode_ff <= csr_wdata[1:0];
            pnf_pkg::CSR_OCTAVE: oct_ff  <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   logic fract;
   logic turb;
   logic [SCW-1:0] top_scale;
   assign fract = (mode_ff == pnf_pkg::MODE_FRACT) || (mode_ff == pnf_pkg::MODE_TURB);
   assign turb  = (mode_ff == pnf_pkg::MODE_TURB);
   always_comb begin
      if (!fract) top_scale = '0;
      else if (32'(oct_ff) > 32'(MAX_OCTAVE)) top_scale = SCW'(MAX_OCTAVE);
      else top_scale = SCW'(oct_ff);
   end

   // issue sequencer: walk scales high to low
   logic               run_ff;
   logic [SCW-1:0]     scl_ff;
   pnf_pkg::req_type   pt_ff;
   logic [7:0]         tag_ff;
   logic               accept;
   logic               issue;
   logic [SCW-1:0]     issue_scale;
   pnf_pkg::req_type   issue_point;

   assign accept = start && !busy;
   assign busy   = run_ff;
   assign issue  = accept || run_ff;
   assign issue_scale = accept ? top_scale : scl_ff;
   assign issue_point = accept ? req_point : pt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         scl_ff <= '0;
         tag_ff <= 8'd0;
      end else begin
         if (accept) begin
            run_ff <= (top_scale != '0);
            scl_ff <= top_scale - SCW'(1);
            pt_ff  <= req_point;
            tag_ff <= {turb, 7'(32'(top_scale))};
         end else if (run_ff) begin
            run_ff <= (scl_ff != '0);
            scl_ff <= scl_ff - SCW'(1);
         end
      end
   end

   logic               s_valid;
   logic signed [19:0] s_sample;
   logic [SCW-1:0]     s_scale;
   logic [7:0]         s_tag;

   pnf_sample #(.SCW(SCW)) u_sample (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue),
      .in_point  (issue_point),
      .in_scale  (issue_scale),
      .seed      (seed_ff),
      .in_tag    (accept ? {turb, 7'(32'(top_scale))} : tag_ff),
      .out_valid (s_valid),
      .out_sample(s_sample),
      .out_scale (s_scale),
      .out_tag   (s_tag)
   );

   // accumulate octave terms; first term of a point is at its top scale
   logic signed [23:0] acc_ff;
   logic signed [23:0] term;
   logic signed [23:0] base;
   logic signed [23:0] total;
   logic               last;
   logic signed [23:0] fin_ff;
   logic               fin_vld_ff;

   always_comb begin
      term  = 24'(s_sample) >>> s_scale;
      if (s_tag[7] && term < 0) term = -term;
      base  = (s_scale == SCW'(s_tag[6:0])) ? 24'sd0 : acc_ff;
      total = base + term;
      last  = (s_scale == '0);
   end

   always_ff @(posedge clock) begin
      if (s_valid) acc_ff <= total;
      if (s_valid && last) fin_ff <= s_tag[7] ? (total <<< 1) - 24'sd65536 : total;
   end

   always_ff @(posedge clock) begin
      if (reset) fin_vld_ff <= 1'b0;
      else       fin_vld_ff <= s_valid && last;
   end

   // scale to Q2.14 and saturate
   logic signed [21:0] q;
   always_comb begin
      q = 22'(fin_ff >>> 2);
      rsp_valid = fin_vld_ff;
      if (q > 22'sd32767) begin
         rsp_result.noise_value = 16'sh7fff;
         rsp_result.saturated_flag = 1'b1;
      end else if (q < -22'sd32768) begin
         rsp_result.noise_value = 16'sh8000;
         rsp_result.saturated_flag = 1'b1;
      end else begin
         rsp_result.noise_value = q[15:0];
         rsp_result.saturated_flag = 1'b0;
      end
   end
endmodule

FILE: rtl/pnf_checker.sv
module pnf_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input pnf_pkg::rsp_type rsp_result
);
   // saturation flag matches a clipped value
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result.saturated_flag |->
      (rsp_result.noise_value == 16'sh7fff || rsp_result.noise_value == 16'sh8000))
      else $error("flag without limit");
   // no response right after reset
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response after reset");
   // busy never starts without an accepted beat
   a_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy without start");
endmodule

bind perlin_noise_3d_fractal pnf_checker u_pnf_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_result(rsp_result)
);

FILE: dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_OCT = 7;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 40;

   logic clock, reset, start, busy, csr_we, rsp_valid;
   pnf_pkg::req_type req_point;
   logic [1:0] csr_index;
   logic [31:0] csr_wdata;
   pnf_pkg::rsp_type rsp_result;

   perlin_noise_3d_fractal u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_point(req_point), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .rsp_valid(rsp_valid), .rsp_result(rsp_result)
   );

   // predictor copy of the registers
   logic [31:0] seed_q;
   logic [1:0]  mode_q;
   logic [2:0]  oct_q;

   pnf_pkg::rsp_type noise_due[$];
   int fail_count;
   int idle_cycles;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // floor division by 2^k
   function automatic longint fshift(input longint v, input int k);
      return v >>> k;
   endfunction

   function automatic logic [3:0] gradient_pick(input logic [31:0] lx, ly, lz);
      logic [31:0] h, sh;
      h = (lx + seed_q) * 32'd71 + (ly + seed_q) * 32'd17 + (lz + seed_q) * 32'd53;
      sh = $unsigned($signed(h) >>> 17);
      h = (sh ^ h) & 32'h7fffffff;
      return h[3:0];
   endfunction

   function automatic longint corner_dot(input logic [31:0] lx, ly, lz,
                                         input longint dx, dy, dz);
      logic [3:0] r;
      int gx, gy, gz;
      r = gradient_pick(lx, ly, lz);
      case (r)
         0, 12: begin gx = 1; gy = 1; gz = 0; end
         1, 13: begin gx = -1; gy = 1; gz = 0; end
         2: begin gx = 1; gy = -1; gz = 0; end
         3: begin gx = -1; gy = -1; gz = 0; end
         4: begin gx = 1; gy = 0; gz = 1; end
         5: begin gx = -1; gy = 0; gz = 1; end
         6: begin gx = 1; gy = 0; gz = -1; end
         7: begin gx = -1; gy = 0; gz = -1; end
         8: begin gx = 0; gy = 1; gz = 1; end
         9, 14: begin gx = 0; gy = -1; gz = 1; end
         10: begin gx = 0; gy = 1; gz = -1; end
         default: begin gx = 0; gy = -1; gz = -1; end
      endcase
      return gx * dx + gy * dy + gz * dz;
   endfunction

   function automatic longint quintic(input longint t);
      logic [63:0] v;
      v = 64'd10 * 64'd4294967296 - 64'd15 * 64'd65536 * t + 64'd6 * t * t;
      v = (v * t) >> 16;
      v = (v * t) >> 16;
      v = (v * t) >> 16;
      return longint'(v >> 16);
   endfunction

   function automatic longint lerp_q16(input longint s, a, b);
      return a + fshift(s * (b - a), 16);
   endfunction

   function automatic longint perlin_at(input longint x, y, z, input int sc);
      longint vx, vy, vz, fx, fy, fz, gx, gy, gz, sx, sy, sz;
      logic [31:0] lx, ly, lz, hx, hy, hz;
      longint c000, c100, c110, c010, c001, c101, c111, c011, t0, t1, b0, b1;
      vx = x <<< sc; vy = y <<< sc; vz = z <<< sc;
      lx = 32'(vx >>> 16); ly = 32'(vy >>> 16); lz = 32'(vz >>> 16);
      fx = vx & 64'hffff; fy = vy & 64'hffff; fz = vz & 64'hffff;
      gx = fx - 65536; gy = fy - 65536; gz = fz - 65536;
      hx = lx + 1; hy = ly + 1; hz = lz + 1;
      c000 = corner_dot(lx, ly, lz, fx, fy, fz);
      c100 = corner_dot(hx, ly, lz, gx, fy, fz);
      c110 = corner_dot(hx, hy, lz, gx, gy, fz);
      c010 = corner_dot(lx, hy, lz, fx, gy, fz);
      c001 = corner_dot(lx, ly, hz, fx, fy, gz);
      c101 = corner_dot(hx, ly, hz, gx, fy, gz);
      c111 = corner_dot(hx, hy, hz, gx, gy, gz);
      c011 = corner_dot(lx, hy, hz, fx, gy, gz);
      sx = quintic(fx); sy = quintic(fy); sz = quintic(fz);
      t0 = lerp_q16(sx, c001, c101);
      t1 = lerp_q16(sx, c011, c111);
      b0 = lerp_q16(sx, c000, c100);
      b1 = lerp_q16(sx, c010, c110);
      return lerp_q16(sz, lerp_q16(sy, b0, b1), lerp_q16(sy, t0, t1));
   endfunction

   function automatic pnf_pkg::rsp_type noise_predict(input pnf_pkg::req_type p);
      longint x, y, z, acc, s, q;
      int n;
      pnf_pkg::rsp_type r;
      x = longint'(p.coord_x); y = longint'(p.coord_y); z = longint'(p.coord_z);
      n = (oct_q > MAX_OCT) ? MAX_OCT : oct_q;
      acc = 0;
      if (mode_q == pnf_pkg::MODE_FRACT || mode_q == pnf_pkg::MODE_TURB) begin
         for (int i = n; i >= 0; i--) begin
            s = fshift(perlin_at(x, y, z, i), i);
            if (mode_q == pnf_pkg::MODE_TURB && s < 0) s = -s;
            acc += s;
         end
         if (mode_q == pnf_pkg::MODE_TURB) acc = 2 * acc - 65536;
      end else begin
         acc = perlin_at(x, y, z, 0);
      end
      q = fshift(acc, 2);
      r.saturated_flag = 1'b0;
      if (q > 32767) begin q = 32767; r.saturated_flag = 1'b1; end
      else if (q < -32768) begin q = -32768; r.saturated_flag = 1'b1; end
      r.noise_value = 16'(q);
      return r;
   endfunction

   // check each result beat against the oldest prediction
   always @(posedge clock) begin
      pnf_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         if (noise_due.size() == 0) begin
            $error("unexpected result beat %h", rsp_result);
            fail_count++;
         end else begin
            e = noise_due.pop_front();
            if (rsp_result.noise_value !== e.noise_value) begin
               $error("noise_value exp %0d got %0d", e.noise_value,
                      rsp_result.noise_value);
               fail_count++;
            end
            if (rsp_result.saturated_flag !== e.saturated_flag) begin
               $error("saturated_flag exp %0d got %0d", e.saturated_flag,
                      rsp_result.saturated_flag);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_we = 1; csr_index = idx; csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
      case (idx)
         pnf_pkg::CSR_SEED:   seed_q = val;
         pnf_pkg::CSR_MODE:   mode_q = val[1:0];
         pnf_pkg::CSR_OCTAVE: oct_q = val[2:0];
         default: ;
      endcase
   endtask

   // hold start until the beat is taken
   task automatic send_point(input logic [31:0] x, y, z);
      pnf_pkg::req_type p;
      p.coord_x = x; p.coord_y = y; p.coord_z = z;
      req_point = p;
      start = 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      noise_due.push_back(noise_predict(p));
      @(negedge clock);
      start = 0;
   endtask

   task automatic random_gap();
      int g;
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) g = 0;
      repeat (g) @(negedge clock);
   endtask

   task automatic drain();
      while (noise_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
         default: return 32'($urandom_range(0, 255)) << 16;
      endcase
   endfunction

   task automatic test_extremes();
      logic [31:0] pts[8] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                              32'h00010000, 32'h0000ffff, 32'hffff0000, 32'h00008000};
      for (int i = 0; i < 8; i++) send_point(pts[i], pts[(i + 3) % 8], pts[(i + 5) % 8]);
      drain();
   endtask

   task automatic test_modes();
      logic [1:0] modes[4] = '{pnf_pkg::MODE_PLAIN, pnf_pkg::MODE_FRACT,
                               pnf_pkg::MODE_TURB, pnf_pkg::MODE_UNUSED};
      for (int m = 0; m < 4; m++) begin
         csr_write(pnf_pkg::CSR_MODE, 32'(modes[m]));
         csr_write(pnf_pkg::CSR_OCTAVE, 32'(m * 2 + 1));
         csr_write(pnf_pkg::CSR_SEED, (m == 1) ? 32'h80000000 : 32'h7fffffff);
         send_point(32'h00018000, 32'hfffe4000, 32'h7fffffff);
         send_point(32'h80000000, 32'h00000000, 32'hffffffff);
         send_point(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f);
         drain();
      end
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 80 == 0) begin
            drain();
            csr_write(pnf_pkg::CSR_SEED,
                      ($urandom_range(0, 3) == 0) ? 32'd55 : $urandom());
            csr_write(pnf_pkg::CSR_MODE, 32'($urandom_range(0, 3)));
            csr_write(pnf_pkg::CSR_OCTAVE,
                      ($urandom_range(0, 3) == 0) ? 32'd7 : 32'($urandom_range(0, 7)));
         end
         send_point(rand_coord(), rand_coord(), rand_coord());
         random_gap();
      end
      drain();
   endtask

   initial begin
      seed_q = 32'd55; mode_q = pnf_pkg::MODE_PLAIN; oct_q = 0;
      fail_count = 0; idle_cycles = 0;
      reset = 1; start = 0; req_point = '0;
      csr_we = 0; csr_index = '0; csr_wdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_extremes();
      test_modes();
      test_random(780);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
